### rtl/core/u8dec_pkg.sv
// Package for the UTF-8 stream validator and decoder.
// Holds byte patterns, second-byte limits, field widths and the count cap.
// No dependencies.
package u8dec_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned CP_W    = 21;
    localparam int unsigned COUNT_W = 17;
    localparam int unsigned LEN_W   = 3;
    localparam int unsigned LEFT_W  = 2;

    // Output word layout: codepoint in the low bits, count above, zero fill to bytes
    localparam int unsigned M_DATA_W = ((CP_W + COUNT_W + 7) / 8) * 8;
    localparam int unsigned M_USER_W = 3;

    // Codepoint count saturates here (string byte budget, capped at the count width)
    localparam logic [COUNT_W-1:0] COUNT_CAP = 17'd65536;

    // Continuation byte form 10xxxxxx
    localparam logic [BYTE_W-1:0] CONT_MASK = 8'hC0;
    localparam logic [BYTE_W-1:0] CONT_TAG  = 8'h80;
    localparam logic [BYTE_W-1:0] PAYLOAD6  = 8'h3F;

    // Lead bytes with a restricted second byte, and their limits
    localparam logic [BYTE_W-1:0] LEAD_E0 = 8'hE0;
    localparam logic [BYTE_W-1:0] MIN_E0  = 8'hA0;
    localparam logic [BYTE_W-1:0] LEAD_ED = 8'hED;
    localparam logic [BYTE_W-1:0] MAX_ED  = 8'h9F;
    localparam logic [BYTE_W-1:0] LEAD_F0 = 8'hF0;
    localparam logic [BYTE_W-1:0] MIN_F0  = 8'h90;
    localparam logic [BYTE_W-1:0] LEAD_F4 = 8'hF4;
    localparam logic [BYTE_W-1:0] MAX_F4  = 8'h8F;

    // Lead payload masks per sequence length
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'h0F;
    localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'h07;

    // Sequence length codes
    localparam logic [LEN_W-1:0] LEN_BAD = 3'd0;
    localparam logic [LEN_W-1:0] LEN_1   = 3'd1;
    localparam logic [LEN_W-1:0] LEN_2   = 3'd2;
    localparam logic [LEN_W-1:0] LEN_3   = 3'd3;
    localparam logic [LEN_W-1:0] LEN_4   = 3'd4;

    // Bit positions in m_tuser
    localparam int unsigned USER_HAS_CP = 0;
    localparam int unsigned USER_ERROR  = 1;
    localparam int unsigned USER_VALID  = 2;

    typedef logic [LEN_W-1:0] seq_len_t;

    // Total sequence length for a lead byte, LEN_BAD if it cannot lead
    function automatic seq_len_t lead_class(input logic [BYTE_W-1:0] b);
        seq_len_t len;
        case (b) inside
            [8'h00:8'h7F]: len = LEN_1;
            [8'hC2:8'hDF]: len = LEN_2;
            [8'hE0:8'hEF]: len = LEN_3;
            [8'hF0:8'hF4]: len = LEN_4;
            default:       len = LEN_BAD;
        endcase
        return len;
    endfunction

endpackage

### rtl/core/utf8_stream_validate_decode.sv
// UTF-8 stream validator and decoder, top level.
// Depends on u8dec_pkg for byte patterns, limits and field widths.
//
// Usage:
//   Slave channel (s_): one byte of a string per word, s_tlast on its final byte.
//   Master channel (m_): one word whenever a byte completes a codepoint, first
//   makes the string invalid, or ends the string (m_tlast). Bytes that open or
//   continue a sequence, and bytes after an error other than the last, give no word.
//   On the last byte's word m_tuser[2] reports string validity and m_tdata carries
//   the count of codepoints completed before any error, saturating at 65536.
// Output: each result is registered, and appears on m_ in the cycle after its byte is accepted.
// Throughput: one byte per cycle while results are taken; decode state and the result register update in
//   the same cycle, so the next byte is taken straight after.
// Stall: a result not yet taken holds in the output register and s_tready drops
//   until m_tready frees it; decode state advances only on accepted bytes.
// Reset: aresetn clears decode state and drops m_tvalid; the first byte after
//   reset starts a new string. State also clears after every last byte.
module utf8_stream_validate_decode
    import u8dec_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [BYTE_W-1:0]   s_tdata,    // [7:0] data_byte
    input  logic                s_tlast,    // last
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,    // [20:0] codepoint, [37:21] codepoint_count, zero fill
    output logic [M_USER_W-1:0] m_tuser,    // [0] has_codepoint, [1] error_here, [2] string_valid
    output logic                m_tlast     // string_done
);

    // Decode state
    logic [BYTE_W-1:0]  lead_reg,    lead_next;
    logic [LEFT_W-1:0]  left_reg,    left_next;
    seq_len_t           len_reg,     len_next;
    logic [CP_W-1:0]    partial_reg, partial_next;
    logic               err_reg,     err_next;
    logic [COUNT_W-1:0] count_reg,   count_next;

    // Output register
    logic               m_valid_reg;
    logic [CP_W-1:0]    cp_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               has_cp_reg, err_here_reg, valid_reg, done_reg;

    // Per-byte decode results
    logic               accept;
    logic               got_cp, err_now, emit;
    logic [CP_W-1:0]    cp_val;
    seq_len_t           lead_len;
    logic               second, bad;
    logic [CP_W-1:0]    shifted;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign lead_len = lead_class(s_tdata);
    assign second   = ({1'b0, left_reg} + 3'd1) == len_reg;
    assign shifted  = {partial_reg[CP_W-7:0], s_tdata[5:0]};

    always_comb begin
        lead_next    = lead_reg;
        left_next    = left_reg;
        len_next     = len_reg;
        partial_next = partial_reg;
        err_next     = err_reg;
        count_next   = count_reg;
        got_cp       = 1'b0;
        cp_val       = '0;
        err_now      = 1'b0;
        bad          = 1'b0;

        if (!err_reg) begin
            if (left_reg == '0) begin
                // Expect a lead byte
                case (lead_len)
                    LEN_1: begin
                        got_cp = 1'b1;
                        cp_val = CP_W'(s_tdata);
                    end
                    LEN_2: begin
                        lead_next    = s_tdata;
                        len_next     = LEN_2;
                        left_next    = 2'd1;
                        partial_next = CP_W'(s_tdata & LEAD2_MASK);
                    end
                    LEN_3: begin
                        lead_next    = s_tdata;
                        len_next     = LEN_3;
                        left_next    = 2'd2;
                        partial_next = CP_W'(s_tdata & LEAD3_MASK);
                    end
                    LEN_4: begin
                        lead_next    = s_tdata;
                        len_next     = LEN_4;
                        left_next    = 2'd3;
                        partial_next = CP_W'(s_tdata & LEAD4_MASK);
                    end
                    default: err_now = 1'b1;
                endcase
            end else begin
                // Expect a continuation byte; apply second-byte limits
                bad = (s_tdata & CONT_MASK) != CONT_TAG;
                if (second) begin
                    if (lead_reg == LEAD_E0 && s_tdata < MIN_E0) bad = 1'b1;
                    if (lead_reg == LEAD_ED && s_tdata > MAX_ED) bad = 1'b1;
                    if (lead_reg == LEAD_F0 && s_tdata < MIN_F0) bad = 1'b1;
                    if (lead_reg == LEAD_F4 && s_tdata > MAX_F4) bad = 1'b1;
                end
                if (bad) begin
                    err_now = 1'b1;
                end else begin
                    left_next    = left_reg - 2'd1;
                    partial_next = shifted;
                    if (left_reg == 2'd1) begin
                        got_cp       = 1'b1;
                        cp_val       = shifted;
                        len_next     = '0;
                        lead_next    = '0;
                        partial_next = '0;
                    end
                end
            end
            if (got_cp && count_reg < COUNT_CAP)
                count_next = count_reg + COUNT_W'(1);
            // Truncated sequence at the end of the string
            if (!err_now && s_tlast && left_next != '0)
                err_now = 1'b1;
            if (err_now)
                err_next = 1'b1;
        end
    end

    assign emit = got_cp || err_now || s_tlast;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lead_reg    <= '0;
            left_reg    <= '0;
            len_reg     <= '0;
            partial_reg <= '0;
            err_reg     <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_tready)
                m_valid_reg <= 1'b0;
            if (accept) begin
                if (s_tlast) begin
                    // Clear for the next string
                    lead_reg    <= '0;
                    left_reg    <= '0;
                    len_reg     <= '0;
                    partial_reg <= '0;
                    err_reg     <= 1'b0;
                    count_reg   <= '0;
                end else begin
                    lead_reg    <= lead_next;
                    left_reg    <= left_next;
                    len_reg     <= len_next;
                    partial_reg <= partial_next;
                    err_reg     <= err_next;
                    count_reg   <= count_next;
                end
                if (emit)
                    m_valid_reg <= 1'b1;
            end
        end
    end

    // Result payload: load only when a word is produced
    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            has_cp_reg    <= got_cp;
            cp_reg        <= cp_val;
            err_here_reg  <= err_now;
            done_reg      <= s_tlast;
            valid_reg     <= s_tlast && !err_next;
            out_count_reg <= count_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_DATA_W - CP_W - COUNT_W)'(0), out_count_reg, cp_reg};
    assign m_tlast  = done_reg;

    always_comb begin
        m_tuser              = '0;
        m_tuser[USER_HAS_CP] = has_cp_reg;
        m_tuser[USER_ERROR]  = err_here_reg;
        m_tuser[USER_VALID]  = valid_reg;
    end

endmodule
